// ===== src/ffwa_pkg.sv =====
// Package for the first-fit core/wavelength allocator.
// Holds the request and result beat types and fixed field widths; no dependencies.
package ffwa_pkg;

   localparam int unsigned NODE_W   = 4;
   localparam int unsigned CORE_W   = 3;
   localparam int unsigned WL_W     = 64;
   localparam int unsigned BW_W     = 16;
   localparam int unsigned CNT_W    = 7;
   localparam int unsigned CTR_W    = 32;

   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [NODE_W-1:0] from_node;
      logic [NODE_W-1:0] to_node;
      logic              last_hop;
      logic [BW_W-1:0]   bandwidth;
      logic [CORE_W-1:0] release_core;
      logic [WL_W-1:0]   release_mask;
   } req_beat_type;

   typedef struct packed {
      logic              accepted;
      logic [CORE_W-1:0] granted_core;
      logic [WL_W-1:0]   granted_mask;
      logic [CNT_W-1:0]  granted_count;
      logic [CTR_W-1:0]  transponders_in_use;
      logic [CTR_W-1:0]  allocated_total;
      logic [CTR_W-1:0]  failed_total;
      logic [CTR_W-1:0]  done_total;
   } rsp_beat_type;

   // Divider control and status between top level and divider.
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

// ===== src/ffwa_div.sv =====
// Restoring bit-serial divider: quotient = ceil(num / den), one bit per cycle.
// Depends on ffwa_pkg.
module ffwa_div
   import ffwa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  div_ctl_type     ctl,
   input  logic [BW_W-1:0] num,
   input  logic [BW_W-1:0] den,
   output div_sts_type     sts,
   output logic [BW_W:0]   quotient
);

   localparam int unsigned STEP_W = $clog2(BW_W + 1);

   logic [BW_W-1:0]   den_ff, den_in;
   logic [BW_W-1:0]   num_ff, num_in;
   logic [BW_W:0]     rem_ff, rem_in;
   logic [BW_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [BW_W:0]     shifted;
   logic [BW_W:0]     diff;

   always_comb begin
      den_in  = den_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[BW_W-1:0], num_ff[BW_W-1]};
      diff    = shifted - {1'b0, den_ff};
      if (ctl.start) begin
         den_in  = (den == '0) ? BW_W'(1) : den;
         num_in  = num;
         rem_in  = '0;
         quo_in  = '0;
         step_in = STEP_W'(BW_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[BW_W-2:0], 1'b0};
         if (!diff[BW_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[BW_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[BW_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Round up when a remainder is left.
   assign quotient = {1'b0, quo_ff} + ((rem_ff != '0) ? (BW_W+1)'(1) : '0);
   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

// ===== src/first_fit_core_wavelength_alloc.sv =====
// First-fit core/wavelength allocator top: sequencer, occupancy and route memories (ffwa_pkg, ffwa_div).
// Flow: a non-final hop is taken in idle; a rejected or overflowed last hop answers straight from idle.
//   A last request hop runs the divider, then per core tried scans every hop and counts the free set;
//   it picks the lowest free ones, writes back each hop and posts. A last release hop starts at the count.
// Throughput: one beat at a time; req_stall stays high until the result beat has been taken.
// Reset (synchronous): clear all 2**(link+core bits) = 2048 occupancy words, one word per cycle, stalled.
module first_fit_core_wavelength_alloc
   import ffwa_pkg::*;
#(
   parameter int unsigned NODES       = 16,
   parameter int unsigned CORES       = 8,
   parameter int unsigned WAVELENGTHS = 64,
   parameter int unsigned MAX_HOPS    = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_beat_type    req_beat,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_beat_type    rsp_beat,
   input  logic            csr_write,
   input  logic [BW_W-1:0] csr_wdata
);

   localparam int unsigned NODE_IW  = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int unsigned CORE_IW  = (CORES > 1) ? $clog2(CORES) : 1;
   localparam int unsigned HOP_IW   = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;
   localparam int unsigned HCNT_W   = $clog2(MAX_HOPS + 1);
   localparam int unsigned LINK_W   = 2 * NODE_IW;
   localparam int unsigned ADDR_W   = LINK_W + CORE_IW;
   localparam int unsigned DEPTH    = 1 << ADDR_W;
   localparam int unsigned WL_IW    = $clog2(WL_W);
   localparam int unsigned PAD_W    = BW_W + 1 - CNT_W;
   localparam logic [WL_W-1:0] WL_MASK =
      (WAVELENGTHS >= 64) ? {WL_W{1'b1}} : ((WL_W'(1) << WAVELENGTHS) - WL_W'(1));

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_SCAN_LINK, ST_SCAN_RD, ST_SCAN_ACC, ST_COUNT,
      ST_PICK, ST_WB_LINK, ST_WB_RD, ST_WB_WR, ST_RESULT
   } state_type;

   // Memories: occupancy per (link, core), route hop store.
   logic [WL_W-1:0]   occ_mem [DEPTH];
   logic [LINK_W-1:0] route_mem [MAX_HOPS];

   state_type          state_ff;
   logic [ADDR_W-1:0]  clr_ff;
   logic [BW_W-1:0]    bwpw_ff;
   logic [HCNT_W-1:0]  hops_ff;
   logic               ovf_ff;
   logic [HOP_IW-1:0]  hop_ff;
   logic [CORE_IW-1:0] core_ff;
   logic               rel_ff;
   logic [WL_W-1:0]    set_ff;      // free set, then grant/release mask
   logic [WL_W-1:0]    grant_ff;
   logic [BW_W:0]      need_ff;     // top bit set marks a blocked request
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   bit_ff;
   logic [WL_W-1:0]    rd_ff;
   logic [LINK_W-1:0]  link_ff;
   logic [CTR_W-1:0]   tsum_ff, alloc_ff, fail_ff, done_ff;
   logic               rsp_valid_ff;
   rsp_beat_type       rsp_ff;

   div_ctl_type        dctl;
   div_sts_type        dsts;
   logic [BW_W:0]      quotient;

   // The divider latches the bandwidth of a last request hop beat on a valid route as it is accepted.
   ffwa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (dctl),
      .num      (req_beat.bandwidth),
      .den      (bwpw_ff),
      .sts      (dsts),
      .quotient (quotient)
   );

   logic hop_ok;
   logic route_bad;
   logic rel_reject;
   logic accept;
   logic [ADDR_W-1:0] addr;
   logic [WL_W-1:0] lowbit;
   logic [CNT_W-1:0] cnt_sum;
   logic last_hop_idx;
   logic last_core;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign hop_ok     = (32'(req_beat.from_node) < NODES)
                    && (32'(req_beat.to_node) < NODES)
                    && (hops_ff < HCNT_W'(MAX_HOPS));
   assign route_bad  = ovf_ff || !hop_ok;
   assign rel_reject = route_bad || (32'(req_beat.release_core) >= CORES);
   assign addr       = {link_ff, core_ff};
   assign lowbit     = set_ff & (~set_ff + WL_W'(1));
   assign cnt_sum    = cnt_ff + CNT_W'(set_ff[bit_ff[WL_IW-1:0]]);
   assign last_hop_idx = ({1'b0, hop_ff} + (HOP_IW+1)'(1)) >= (HOP_IW+1)'(hops_ff);
   assign last_core  = ({1'b0, core_ff} == (CORE_IW+1)'(CORES - 1));

   // Route hop store write; link read for the current hop.
   always_ff @(posedge clock) begin
      if (accept && hop_ok)
         route_mem[hops_ff[HOP_IW-1:0]] <= {NODE_IW'(req_beat.from_node),
                                            NODE_IW'(req_beat.to_node)};
      link_ff <= route_mem[hop_ff];
   end

   // Occupancy memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR)
         occ_mem[clr_ff] <= '0;
      else if (state_ff == ST_WB_WR)
         occ_mem[addr] <= rel_ff ? (rd_ff & ~set_ff) : (rd_ff | set_ff);
      rd_ff <= occ_mem[addr];
   end

   always_comb begin
      dctl.start = accept && req_beat.last_hop && (req_beat.cmd == CMD_REQUEST)
                && !ovf_ff && hop_ok;
   end

   // Sequencer. Each hop visit latches the link, reads the occupancy word,
   // then uses the registered word.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         bwpw_ff      <= BW_W'(100);
         hops_ff      <= '0;
         ovf_ff       <= 1'b0;
         tsum_ff      <= '0;
         alloc_ff     <= '0;
         fail_ff      <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write)
            bwpw_ff <= csr_wdata;
         // Drop the result beat once taken; new beats are accepted only in idle with no result pending.
         if (rsp_valid_ff && !rsp_stall)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (&clr_ff)
                  state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (accept && !req_beat.last_hop) begin
                  // Store the hop, or mark the route as overflowed and drop it.
                  if (hop_ok)
                     hops_ff <= hops_ff + HCNT_W'(1);
                  else
                     ovf_ff <= 1'b1;
               end else if (accept) begin
                  // Last hop: its fields decide the action; collection restarts.
                  ovf_ff <= 1'b0;
                  hop_ff <= '0;
                  rel_ff <= (req_beat.cmd == CMD_RELEASE);
                  if (req_beat.cmd == CMD_RELEASE) begin
                     if (rel_reject) begin
                        hops_ff <= '0;
                        rsp_ff <= {1'b0, CORE_W'(0), WL_W'(0), CNT_W'(0),
                                   tsum_ff, alloc_ff, fail_ff, done_ff};
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        hops_ff <= hops_ff + HCNT_W'(1);
                        set_ff <= req_beat.release_mask & WL_MASK;
                        core_ff <= CORE_IW'(req_beat.release_core);
                        cnt_ff <= '0;
                        bit_ff <= '0;
                        state_ff <= ST_COUNT;
                     end
                  end else if (route_bad) begin
                     hops_ff <= '0;
                     fail_ff <= fail_ff + CTR_W'(1);
                     done_ff <= done_ff + CTR_W'(1);
                     rsp_ff <= {1'b0, CORE_W'(0), WL_W'(0), CNT_W'(0), tsum_ff, alloc_ff,
                                fail_ff + CTR_W'(1), done_ff + CTR_W'(1)};
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     hops_ff <= hops_ff + HCNT_W'(1);
                     core_ff <= '0;
                     state_ff <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               if (dsts.done) begin
                  if (quotient > (BW_W+1)'(WAVELENGTHS)) begin
                     need_ff <= '1;
                     state_ff <= ST_RESULT;
                  end else begin
                     need_ff <= quotient;
                     set_ff <= WL_MASK;
                     hop_ff <= '0;
                     state_ff <= ST_SCAN_LINK;
                  end
               end
            end
            ST_SCAN_LINK: state_ff <= ST_SCAN_RD;
            ST_SCAN_RD:   state_ff <= ST_SCAN_ACC;
            ST_SCAN_ACC: begin
               // Narrow the common free set by this hop's occupancy.
               set_ff <= set_ff & ~rd_ff;
               if (last_hop_idx) begin
                  cnt_ff <= '0;
                  bit_ff <= '0;
                  state_ff <= ST_COUNT;
               end else begin
                  hop_ff <= hop_ff + HOP_IW'(1);
                  state_ff <= ST_SCAN_LINK;
               end
            end
            ST_COUNT: begin
               // Count set bits, one per cycle.
               if (bit_ff != CNT_W'(WL_W - 1)) begin
                  cnt_ff <= cnt_sum;
                  bit_ff <= bit_ff + CNT_W'(1);
               end else if (rel_ff) begin
                  cnt_ff <= cnt_sum;
                  hop_ff <= '0;
                  state_ff <= ST_WB_LINK;
               end else if ({{PAD_W{1'b0}}, cnt_sum} >= need_ff) begin
                  cnt_ff <= '0;
                  grant_ff <= '0;
                  state_ff <= ST_PICK;
               end else if (last_core) begin
                  need_ff <= '1;
                  state_ff <= ST_RESULT;
               end else begin
                  // Advance to the next core and rescan the route.
                  core_ff <= core_ff + CORE_IW'(1);
                  set_ff <= WL_MASK;
                  hop_ff <= '0;
                  state_ff <= ST_SCAN_LINK;
               end
            end
            ST_PICK: begin
               if ({{PAD_W{1'b0}}, cnt_ff} < need_ff) begin
                  // Peel the lowest free wavelength into the grant.
                  set_ff <= set_ff & ~lowbit;
                  grant_ff <= grant_ff | lowbit;
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end else begin
                  set_ff <= grant_ff;
                  hop_ff <= '0;
                  state_ff <= ST_WB_LINK;
               end
            end
            ST_WB_LINK: state_ff <= ST_WB_RD;
            ST_WB_RD:   state_ff <= ST_WB_WR;
            ST_WB_WR: begin
               // The word is written back this cycle; move to the next hop.
               if (last_hop_idx) begin
                  state_ff <= ST_RESULT;
               end else begin
                  hop_ff <= hop_ff + HOP_IW'(1);
                  state_ff <= ST_WB_LINK;
               end
            end
            ST_RESULT: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
               hops_ff <= '0;
               if (rel_ff) begin
                  tsum_ff <= tsum_ff - CTR_W'(cnt_ff);
                  done_ff <= done_ff + CTR_W'(1);
                  rsp_ff <= {1'b1, CORE_W'(core_ff), set_ff, cnt_ff,
                             tsum_ff - CTR_W'(cnt_ff), alloc_ff, fail_ff,
                             done_ff + CTR_W'(1)};
               end else if (need_ff[BW_W]) begin
                  fail_ff <= fail_ff + CTR_W'(1);
                  done_ff <= done_ff + CTR_W'(1);
                  rsp_ff <= {1'b0, CORE_W'(0), WL_W'(0), CNT_W'(0), tsum_ff, alloc_ff,
                             fail_ff + CTR_W'(1), done_ff + CTR_W'(1)};
               end else begin
                  tsum_ff <= tsum_ff + CTR_W'(cnt_ff);
                  alloc_ff <= alloc_ff + CTR_W'(1);
                  rsp_ff <= {1'b1, CORE_W'(core_ff), set_ff, cnt_ff,
                             tsum_ff + CTR_W'(cnt_ff), alloc_ff + CTR_W'(1), fail_ff,
                             done_ff};
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule
